[rtl/sip_pkg.sv]
`timescale 1ns / 1ps

package sip_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 2;
   localparam int REM_BITS   = CROSS_BITS + 2;
   localparam int QUOT_BITS  = DIFF_BITS + 1;
   localparam int CELL_COUNT = DIFF_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] cross_x;
      logic signed [COORD_BITS-1:0] cross_y;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic                         hit;
      logic                         neg_x;
      logic                         neg_y;
      logic [DIFF_BITS-1:0]         mag_x;
      logic [DIFF_BITS-1:0]         mag_y;
      logic [CROSS_BITS-1:0]        num;
      logic [CROSS_BITS-1:0]        den;
      logic signed [COORD_BITS-1:0] ax1;
      logic signed [COORD_BITS-1:0] ay1;
      logic [REM_BITS-1:0]          rem_x;
      logic [REM_BITS-1:0]          rem_y;
      logic [QUOT_BITS-1:0]         quot_x;
      logic [QUOT_BITS-1:0]         quot_y;
   } cell_type;

endpackage

[rtl/sip_front.sv]
`timescale 1ns / 1ps

module sip_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sip_pkg::req_type  in_data,
   output sip_pkg::cell_type out_cell
);
   import sip_pkg::*;

   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [DIFF_BITS-1:0] dax_ff, day_ff, dbx_ff, dby_ff, ex_ff, ey_ff;
   logic signed [DIFF_BITS-1:0] dax2_ff, day2_ff, dax3_ff, day3_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff, ax12_ff, ay12_ff, ax13_ff, ay13_ff;
   logic signed [PROD_BITS-1:0] p_den0_ff, p_den1_ff, p_t0_ff, p_t1_ff, p_s0_ff, p_s1_ff;
   logic signed [CROSS_BITS-1:0] den_ff, tn_ff, sn_ff;
   cell_type                    cell_ff, cell_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         cell_ff.valid <= cell_in.valid;
      end
      dax_ff <= DIFF_BITS'(in_data.a_end_x) - DIFF_BITS'(in_data.a_start_x);
      day_ff <= DIFF_BITS'(in_data.a_end_y) - DIFF_BITS'(in_data.a_start_y);
      dbx_ff <= DIFF_BITS'(in_data.b_end_x) - DIFF_BITS'(in_data.b_start_x);
      dby_ff <= DIFF_BITS'(in_data.b_end_y) - DIFF_BITS'(in_data.b_start_y);
      ex_ff  <= DIFF_BITS'(in_data.a_start_x) - DIFF_BITS'(in_data.b_start_x);
      ey_ff  <= DIFF_BITS'(in_data.a_start_y) - DIFF_BITS'(in_data.b_start_y);
      ax1_ff <= in_data.a_start_x;
      ay1_ff <= in_data.a_start_y;

      p_den0_ff <= PROD_BITS'(dby_ff * dax_ff);
      p_den1_ff <= PROD_BITS'(dbx_ff * day_ff);
      p_t0_ff   <= PROD_BITS'(dbx_ff * ey_ff);
      p_t1_ff   <= PROD_BITS'(dby_ff * ex_ff);
      p_s0_ff   <= PROD_BITS'(dax_ff * ey_ff);
      p_s1_ff   <= PROD_BITS'(day_ff * ex_ff);
      dax2_ff <= dax_ff;
      day2_ff <= day_ff;
      ax12_ff <= ax1_ff;
      ay12_ff <= ay1_ff;

      den_ff <= CROSS_BITS'(p_den0_ff) - CROSS_BITS'(p_den1_ff);
      tn_ff  <= CROSS_BITS'(p_t0_ff) - CROSS_BITS'(p_t1_ff);
      sn_ff  <= CROSS_BITS'(p_s0_ff) - CROSS_BITS'(p_s1_ff);
      dax3_ff <= dax2_ff;
      day3_ff <= day2_ff;
      ax13_ff <= ax12_ff;
      ay13_ff <= ay12_ff;

      cell_ff.hit    <= cell_in.hit;
      cell_ff.neg_x  <= cell_in.neg_x;
      cell_ff.neg_y  <= cell_in.neg_y;
      cell_ff.mag_x  <= cell_in.mag_x;
      cell_ff.mag_y  <= cell_in.mag_y;
      cell_ff.num    <= cell_in.num;
      cell_ff.den    <= cell_in.den;
      cell_ff.ax1    <= cell_in.ax1;
      cell_ff.ay1    <= cell_in.ay1;
      cell_ff.rem_x  <= cell_in.rem_x;
      cell_ff.rem_y  <= cell_in.rem_y;
      cell_ff.quot_x <= cell_in.quot_x;
      cell_ff.quot_y <= cell_in.quot_y;
   end

   logic                  flip;
   logic [CROSS_BITS-1:0] den_n, tn_n, sn_n;

   always_comb begin
      flip  = den_ff[CROSS_BITS-1];
      den_n = flip ? -den_ff : den_ff;
      tn_n  = flip ? -tn_ff : tn_ff;
      sn_n  = flip ? -sn_ff : sn_ff;
      cell_in.valid  = s3_valid_ff;
      cell_in.hit    = (den_ff != '0) && !tn_n[CROSS_BITS-1] && !sn_n[CROSS_BITS-1]
                       && (tn_n <= den_n) && (sn_n <= den_n)
                       && !((tn_n == '0) && (sn_n == '0));
      cell_in.neg_x  = dax3_ff[DIFF_BITS-1];
      cell_in.neg_y  = day3_ff[DIFF_BITS-1];
      cell_in.mag_x  = dax3_ff[DIFF_BITS-1] ? -dax3_ff : dax3_ff;
      cell_in.mag_y  = day3_ff[DIFF_BITS-1] ? -day3_ff : day3_ff;
      cell_in.num    = tn_n;
      cell_in.den    = den_n;
      cell_in.ax1    = ax13_ff;
      cell_in.ay1    = ay13_ff;
      cell_in.rem_x  = '0;
      cell_in.rem_y  = '0;
      cell_in.quot_x = '0;
      cell_in.quot_y = '0;
   end

   assign out_cell = cell_ff;

endmodule

[rtl/sip_cell.sv]
`timescale 1ns / 1ps

module sip_cell (
   input  logic              clock,
   input  logic              reset,
   input  sip_pkg::cell_type in_cell,
   output sip_pkg::cell_type out_cell
);
   import sip_pkg::*;

   cell_type cell_ff, cell_in;

   function automatic logic [REM_BITS+QUOT_BITS-1:0] div_step(
      input logic [REM_BITS-1:0]   rem,
      input logic [QUOT_BITS-1:0]  quot,
      input logic                  bit_in,
      input logic [CROSS_BITS-1:0] num,
      input logic [CROSS_BITS-1:0] den);
      logic [REM_BITS-1:0]  t;
      logic [REM_BITS-1:0]  d1;
      logic [REM_BITS-1:0]  d2;
      logic [QUOT_BITS-1:0] q;
      t  = {rem[REM_BITS-2:0], 1'b0} + (bit_in ? REM_BITS'(num) : '0);
      d1 = REM_BITS'(den);
      d2 = {d1[REM_BITS-2:0], 1'b0};
      q  = {quot[QUOT_BITS-2:0], 1'b0};
      if (t >= d2) begin
         t = t - d2;
         q = q + QUOT_BITS'(2);
      end else if (t >= d1) begin
         t = t - d1;
         q = q + QUOT_BITS'(1);
      end
      return {t, q};
   endfunction

   always_comb begin
      cell_in = in_cell;
      {cell_in.rem_x, cell_in.quot_x} = div_step(in_cell.rem_x, in_cell.quot_x,
         in_cell.mag_x[DIFF_BITS-1], in_cell.num, in_cell.den);
      {cell_in.rem_y, cell_in.quot_y} = div_step(in_cell.rem_y, in_cell.quot_y,
         in_cell.mag_y[DIFF_BITS-1], in_cell.num, in_cell.den);
      cell_in.mag_x = {in_cell.mag_x[DIFF_BITS-2:0], 1'b0};
      cell_in.mag_y = {in_cell.mag_y[DIFF_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.hit    <= cell_in.hit;
      cell_ff.neg_x  <= cell_in.neg_x;
      cell_ff.neg_y  <= cell_in.neg_y;
      cell_ff.mag_x  <= cell_in.mag_x;
      cell_ff.mag_y  <= cell_in.mag_y;
      cell_ff.num    <= cell_in.num;
      cell_ff.den    <= cell_in.den;
      cell_ff.ax1    <= cell_in.ax1;
      cell_ff.ay1    <= cell_in.ay1;
      cell_ff.rem_x  <= cell_in.rem_x;
      cell_ff.rem_y  <= cell_in.rem_y;
      cell_ff.quot_x <= cell_in.quot_x;
      cell_ff.quot_y <= cell_in.quot_y;
   end

   assign out_cell = cell_ff;

endmodule

[rtl/segment_intersection_point.sv]
`timescale 1ns / 1ps

// One segment pair is taken in every clock cycle and busy never rises. Each
// result appears on the rsp_ ports for a single cycle with rsp_strobe high,
// once its transfer has passed four front stages, one divider cell per bit
// of the direction magnitude and one output register. The receiver
// cannot stall the block and must take every result in the cycle it appears.

module segment_intersection_point (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sip_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sip_pkg::rsp_type rsp_data
);
   import sip_pkg::*;

   cell_type chain [CELL_COUNT+1];
   logic     strobe_ff;
   rsp_type  data_ff, data_in;

   assign busy = 1'b0;

   sip_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .out_cell (chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      sip_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   logic signed [QUOT_BITS:0] off_x, off_y, sum_x, sum_y;

   always_comb begin
      off_x = chain[CELL_COUNT].neg_x ? -$signed({1'b0, chain[CELL_COUNT].quot_x})
                                      : $signed({1'b0, chain[CELL_COUNT].quot_x});
      off_y = chain[CELL_COUNT].neg_y ? -$signed({1'b0, chain[CELL_COUNT].quot_y})
                                      : $signed({1'b0, chain[CELL_COUNT].quot_y});
      sum_x = (QUOT_BITS+1)'(chain[CELL_COUNT].ax1) + off_x;
      sum_y = (QUOT_BITS+1)'(chain[CELL_COUNT].ay1) + off_y;
      data_in.hit     = chain[CELL_COUNT].hit;
      data_in.cross_x = chain[CELL_COUNT].hit ? sum_x[COORD_BITS-1:0] : '0;
      data_in.cross_y = chain[CELL_COUNT].hit ? sum_y[COORD_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain[CELL_COUNT].valid;
      end
      data_ff <= data_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

[dv/tb_segment_intersection_point.sv]
`timescale 1ns / 1ps

module tb_segment_intersection_point;
   import sip_pkg::*;

   class crossing_board;
      rsp_type pending[$];
      int errors;
      int hits;
      int seen;

      function automatic logic signed [63:0] offset_of(logic [127:0] num,
                                                       logic [127:0] den,
                                                       logic signed [63:0] d);
         logic [127:0] q;
         logic [63:0] md;
         md = d < 0 ? -d : d;
         q = (num * md) / den;
         return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
      endfunction

      function void note_pair(req_type r);
         logic signed [63:0] ax1, ay1, dax, day, dbx, dby, ex, ey;
         logic signed [127:0] den, tn, sn;
         rsp_type e;
         logic h;
         ax1 = r.a_start_x;
         ay1 = r.a_start_y;
         dax = 64'(r.a_end_x) - ax1;
         day = 64'(r.a_end_y) - ay1;
         dbx = 64'(r.b_end_x) - 64'(r.b_start_x);
         dby = 64'(r.b_end_y) - 64'(r.b_start_y);
         ex = ax1 - 64'(r.b_start_x);
         ey = ay1 - 64'(r.b_start_y);
         den = 128'(dby) * 128'(dax) - 128'(dbx) * 128'(day);
         tn = 128'(dbx) * 128'(ey) - 128'(dby) * 128'(ex);
         sn = 128'(dax) * 128'(ey) - 128'(day) * 128'(ex);
         h = 1'b1;
         e = '0;
         if (den == 0) begin
            h = 1'b0;
         end else begin
            if (den < 0) begin
               den = -den;
               tn = -tn;
               sn = -sn;
            end
            if (tn < 0 || sn < 0 || tn > den || sn > den) h = 1'b0;
            else if (tn == 0 && sn == 0) h = 1'b0;
         end
         if (h) begin
            e.hit = 1'b1;
            e.cross_x = COORD_BITS'(ax1 + offset_of(tn, den, dax));
            e.cross_y = COORD_BITS'(ay1 + offset_of(tn, den, day));
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, a.hit,
                     a.cross_x, a.cross_y);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.hit) hits++;
         if (a.hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, a.hit);
            errors++;
         end
         if (a.cross_x !== e.cross_x) begin
            $display("%0t: cross_x expected %0d actual %0d", $time, e.cross_x,
                     a.cross_x);
            errors++;
         end
         if (a.cross_y !== e.cross_y) begin
            $display("%0t: cross_y expected %0d actual %0d", $time, e.cross_y,
                     a.cross_y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   int idle_pct = 0;
   crossing_board board = new();

   localparam logic signed [23:0] MAXC = 24'sh7FFFFF;
   localparam logic signed [23:0] MINC = -24'sh800000;
   localparam logic signed [23:0] ONE = 24'sh001000;

   segment_intersection_point dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_data);
   end

   function automatic logic signed [23:0] rnd_coord(int mode);
      if (mode == 0) return 24'($urandom);
      return 24'($signed($urandom_range(0, 2 * 16384)) - 16384);
   endfunction

   task automatic send_pair(req_type r);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_pair(r);
   endtask

   task automatic send_seg(logic signed [23:0] a0, a1, a2, a3, b0, b1, b2, b3);
      send_pair('{a0, a1, a2, a3, b0, b1, b2, b3});
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_pairs(int count);
      req_type r;
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(3, 0);
         r = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
         case ($urandom_range(5, 0))
            0: begin
               r.b_start_x = 24'(r.a_start_x + (r.a_end_x - r.a_start_x) / 2
                                 - (r.b_end_x - r.b_start_x) / 2);
               r.b_start_y = 24'(r.a_start_y + (r.a_end_y - r.a_start_y) / 2
                                 - (r.b_end_y - r.b_start_y) / 2);
            end
            1: begin
               r.b_start_x = r.a_end_x;
               r.b_start_y = r.a_end_y;
            end
            2: begin
               r.b_end_x = r.b_start_x + (r.a_end_x - r.a_start_x);
               r.b_end_y = r.b_start_y + (r.a_end_y - r.a_start_y);
            end
            default: ;
         endcase
         send_pair(r);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_seg(0, 0, ONE, ONE, 0, ONE, ONE, 0);
      send_seg(0, 0, ONE, 0, 0, ONE, ONE, ONE);
      send_seg(0, 0, ONE, 0, 24'(2 * ONE), 0, 24'(3 * ONE), 0);
      send_seg(0, 0, 0, 0, 0, 0, ONE, ONE);
      send_seg(0, 0, ONE, 0, 24'(2 * ONE), -ONE, 24'(2 * ONE), ONE);
      send_seg(0, 0, ONE, 0, ONE, 0, ONE, ONE);
      send_seg(0, 0, ONE, 0, 0, 0, 0, ONE);
      send_seg(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
      send_seg(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
      send_seg(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
      send_seg(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC);
      send_seg(-ONE, -ONE, 3, 7, -5, 9, 11, -13);
      send_seg(MINC, MINC, MAXC, MINC, MAXC, MINC, MINC, MINC);
      drain();
      idle_pct = 33;
      random_pairs(280);
      drain();
      idle_pct = 87;
      random_pairs(280);
      idle_pct = 0;
      random_pairs(280);
      drain();
      $display("Covered %0d segment pairs, %0d of them hits, over three idle profiles.",
               board.seen, board.hits);
      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
